/* sv/rfsd_pkg.sv */
// Run-length frame span decoder: shared package.
// Item structs, controller/datapath command and status structs, register
// indexes and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package rfsd_pkg;

	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 11;
	localparam int PITCH_W    = 12;
	localparam int PL_W       = WIDTH_W + HEIGHT_W;
	localparam int ROW_W      = 21;
	localparam int FULL_W     = 11;
	localparam int TAIL_W     = 10;
	localparam int COLOR_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// restoring divider, quotient bits per cycle
	localparam int DIV_STEPS = 4;
	localparam int DIV_CYC   = (PL_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_W     = DIV_CYC * DIV_STEPS;
	localparam int CNT_W     = $clog2(DIV_CYC);

	localparam logic [7:0]         VARINT_CONT = 8'h80;
	localparam logic [7:0]         VARINT_MASK = 8'h7F;
	localparam logic [COLOR_W-1:0] BLACK       = 16'h0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_LINE_PITCH   = 3'd2,
		REG_VARINT_MODE  = 3'd3,
		REG_BINARY_MODE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]   start_offset;
		logic [WIDTH_W-1:0] head_len;
		logic [FULL_W-1:0]  full_rows;
		logic [TAIL_W-1:0]  tail_len;
		logic [COLOR_W-1:0] fill_color;
		logic               clipped;
		logic               frame_full;
	} out_item_t;

	typedef struct packed {
		logic cfg_we;
		logic latch;
		logic parse;
		logic clip;
		logic place;
		logic div_step;
		logic mul;
		logic adv;
		logic emit;
		logic init;
	} dp_cmd_t;

	typedef struct packed {
		logic geo_wr;
		logic is_eof;
		logic run_go;
		logic place_long;
		logic out_free;
	} dp_status_t;

endpackage

/* sv/rfsd_ctrl.sv */
// Run-length frame span decoder: controller state machine.
// Sequences one item through parse, clip, place, divide, multiply, advance and emit.
// Depends on rfsd_pkg.
`timescale 1ns / 1ps

module rfsd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                cfg_valid,
	input  rfsd_pkg::dp_status_t st,
	output logic                in_stall,
	output logic                cfg_ready,
	output rfsd_pkg::dp_cmd_t   cmd
);
	import rfsd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PARSE, S_CLIP, S_PLACE, S_DIV, S_MUL, S_ADV, S_EMIT, S_WAIT, S_INIT
	} state_t;

	state_t           state_q;
	logic             eof_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eof_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						if (st.geo_wr) state_q <= S_WAIT;
					end else if (in_valid) begin
						state_q <= S_PARSE;
					end
				end
				S_PARSE: begin
					eof_q <= st.is_eof;
					if (st.run_go) state_q <= S_CLIP;
					else if (st.is_eof) state_q <= S_INIT;
					else state_q <= S_IDLE;
				end
				S_CLIP: state_q <= S_PLACE;
				S_PLACE: begin
					cnt_q <= '0;
					state_q <= st.place_long ? S_DIV : S_EMIT;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_CYC - 1)) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ADV;
				S_ADV: state_q <= S_EMIT;
				S_EMIT: begin
					if (st.out_free) state_q <= eof_q ? S_INIT : S_IDLE;
				end
				S_WAIT: state_q <= S_INIT;
				S_INIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_stall     = (state_q != S_IDLE) || cfg_valid;
		cfg_ready    = (state_q == S_IDLE);
		cmd          = '0;
		cmd.cfg_we   = cfg_valid && (state_q == S_IDLE);
		cmd.latch    = in_valid && !cfg_valid && (state_q == S_IDLE);
		cmd.parse    = (state_q == S_PARSE);
		cmd.clip     = (state_q == S_CLIP);
		cmd.place    = (state_q == S_PLACE);
		cmd.div_step = (state_q == S_DIV);
		cmd.mul      = (state_q == S_MUL);
		cmd.adv      = (state_q == S_ADV);
		cmd.emit     = (state_q == S_EMIT) && st.out_free;
		cmd.init     = (state_q == S_INIT);
	end

	property p_emit_holds;
		@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && !st.out_free |=> (state_q == S_EMIT);
	endproperty
	a_emit_holds: assert property (p_emit_holds) else $error("emit left before output free");

	property p_div_length;
		@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> $past(state_q) == S_DIV;
	endproperty
	a_div_length: assert property (p_div_length) else $error("multiply without divide");

	property p_cfg_only_idle;
		@(posedge clk) disable iff (!arst_n)
		cmd.cfg_we |-> !cmd.latch;
	endproperty
	a_cfg_only_idle: assert property (p_cfg_only_idle) else $error("config write with item");

endmodule

/* sv/rfsd_dpath.sv */
// Run-length frame span decoder: datapath.
// Config registers, token parser, cursor, clip, divider and pitch
// multiplier, output register. Depends on rfsd_pkg.
`timescale 1ns / 1ps

module rfsd_dpath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_PITCH  = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rfsd_pkg::dp_cmd_t                   cmd,
	output rfsd_pkg::dp_status_t                st,
	input  logic [rfsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rfsd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  rfsd_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rfsd_pkg::out_item_t                 out_data
);
	import rfsd_pkg::*;

	localparam int PROD_W = PITCH_W + FULL_W + 1;

	typedef enum logic [1:0] {PH_LEN0, PH_LEN1, PH_COL0, PH_COL1} phase_t;

	// configuration
	logic [WIDTH_W-1:0]  fw_q;
	logic [HEIGHT_W-1:0] fh_q;
	logic [PITCH_W-1:0]  lp_q;
	logic                vmode_q, bmode_q;
	logic [WIDTH_W-1:0]  w_eff, w_q;
	logic [HEIGHT_W-1:0] h_eff;
	logic [PITCH_W-1:0]  p_eff, p_q;
	logic [PL_W-1:0]     area_d, area_q;

	// token and cursor
	in_item_t            item_q;
	phase_t              phase_q, nxt_phase;
	logic [7:0]          held_q, nxt_held;
	logic [15:0]         runlen_q, nxt_runlen, len_val;
	logic [COLOR_W-1:0]  runcol_q, nxt_runcol, run_col;
	logic [PL_W-1:0]     run_len;
	logic                run_go, len_done;
	logic [WIDTH_W-1:0]  col_q;
	logic [ROW_W-1:0]    rowb_q;
	logic [PL_W-1:0]     pl_q;

	// run in flight
	logic [PL_W-1:0]     len_q, clen;
	logic                over;
	logic [COLOR_W-1:0]  fcol_q;
	logic [ROW_W-1:0]    off_q;
	logic [WIDTH_W-1:0]  head_q, room, ncol;
	logic                clip_q, ffull_q, is_short;
	logic [DIV_W-1:0]    quot_q, q_nx;
	logic [WIDTH_W-1:0]  rem_q, r_nx;
	logic [PROD_W-1:0]   prod_w;
	logic [ROW_W-1:0]    prod_q;
	logic                out_valid_q;

	always_comb begin
		w_eff = fw_q;
		if (fw_q == '0) w_eff = WIDTH_W'(1);
		else if (32'(fw_q) > MAX_WIDTH) w_eff = WIDTH_W'(MAX_WIDTH);
		h_eff = fh_q;
		if (fh_q == '0) h_eff = HEIGHT_W'(1);
		else if (32'(fh_q) > MAX_HEIGHT) h_eff = HEIGHT_W'(MAX_HEIGHT);
		p_eff = lp_q;
		if (32'(lp_q) > MAX_PITCH) p_eff = PITCH_W'(MAX_PITCH);
		if (p_eff < PITCH_W'(w_eff)) p_eff = PITCH_W'(w_eff);
		area_d = {{(PL_W - WIDTH_W){1'b0}}, w_eff} * {{(PL_W - HEIGHT_W){1'b0}}, h_eff};
	end

	assign st.geo_wr = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT)
		|| (cfg_index == REG_LINE_PITCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= WIDTH_W'(1);
			fh_q    <= HEIGHT_W'(1);
			lp_q    <= PITCH_W'(1);
			vmode_q <= 1'b0;
			bmode_q <= 1'b0;
			w_q     <= WIDTH_W'(1);
			p_q     <= PITCH_W'(1);
			area_q  <= PL_W'(1);
		end else begin
			w_q    <= w_eff;
			p_q    <= p_eff;
			area_q <= area_d;
			if (cmd.cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  fw_q    <= cfg_data[WIDTH_W-1:0];
					REG_FRAME_HEIGHT: fh_q    <= cfg_data[HEIGHT_W-1:0];
					REG_LINE_PITCH:   lp_q    <= cfg_data;
					REG_VARINT_MODE:  vmode_q <= cfg_data[0];
					REG_BINARY_MODE:  bmode_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// token parser
	always_comb begin
		nxt_phase  = phase_q;
		nxt_held   = held_q;
		nxt_runlen = runlen_q;
		nxt_runcol = runcol_q;
		len_done   = 1'b0;
		len_val    = '0;
		run_go     = 1'b0;
		run_len    = PL_W'(runlen_q);
		run_col    = runcol_q;
		if (item_q.opcode) begin
			run_go  = (pl_q != '0);
			run_len = pl_q;
			run_col = BLACK;
		end else if (pl_q != '0) begin
			case (phase_q)
				PH_LEN0: begin
					if (vmode_q && ((item_q.byte_value & VARINT_CONT) == 8'h00)) begin
						len_done = 1'b1;
						len_val  = {8'h00, item_q.byte_value};
					end else begin
						nxt_held  = vmode_q ? (item_q.byte_value & VARINT_MASK)
							: item_q.byte_value;
						nxt_phase = PH_LEN1;
					end
				end
				PH_LEN1: begin
					len_done = 1'b1;
					len_val  = vmode_q ? {held_q, item_q.byte_value}
						: {item_q.byte_value, held_q};
				end
				PH_COL0: begin
					nxt_held  = item_q.byte_value;
					nxt_phase = PH_COL1;
				end
				PH_COL1: begin
					nxt_runcol = {item_q.byte_value, held_q};
					run_col    = {item_q.byte_value, held_q};
					nxt_phase  = PH_LEN0;
					run_go     = (runlen_q != '0);
				end
				default: nxt_phase = PH_LEN0;
			endcase
			if (len_done) begin
				nxt_runlen = len_val;
				run_len    = PL_W'(len_val);
				if (!bmode_q) begin
					nxt_phase = PH_COL0;
				end else begin
					nxt_phase  = PH_LEN0;
					run_go     = (len_val != '0);
					nxt_runcol = ~runcol_q;
				end
			end
		end
	end

	assign over     = len_q > pl_q;
	assign clen     = over ? pl_q : len_q;
	assign room     = w_q - col_q;
	assign is_short = len_q <= PL_W'(room);
	assign ncol     = col_q + len_q[WIDTH_W-1:0];
	assign prod_w   = {{(PROD_W - PITCH_W){1'b0}}, p_q}
		* ({{(PROD_W - FULL_W){1'b0}}, quot_q[FULL_W-1:0]} + PROD_W'(1));

	// restoring divide by width, DIV_STEPS quotient bits a cycle
	always_comb begin
		logic [WIDTH_W:0] rs;
		q_nx = quot_q;
		r_nx = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			rs   = {r_nx, q_nx[DIV_W-1]};
			q_nx = {q_nx[DIV_W-2:0], 1'b0};
			if (rs >= {1'b0, w_q}) begin
				rs      = rs - {1'b0, w_q};
				q_nx[0] = 1'b1;
			end
			r_nx = rs[WIDTH_W-1:0];
		end
	end

	assign st.is_eof     = item_q.opcode;
	assign st.run_go     = run_go;
	assign st.place_long = !is_short;
	assign st.out_free   = !out_valid_q || !out_stall;

	// control-side state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN0;
			held_q      <= '0;
			runlen_q    <= '0;
			runcol_q    <= BLACK;
			col_q       <= '0;
			rowb_q      <= '0;
			pl_q        <= PL_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.parse) begin
				phase_q  <= nxt_phase;
				held_q   <= nxt_held;
				runlen_q <= nxt_runlen;
				runcol_q <= nxt_runcol;
			end
			if (cmd.clip) pl_q <= pl_q - clen;
			if (cmd.place && is_short) begin
				if (ncol == w_q) begin
					col_q  <= '0;
					rowb_q <= rowb_q + ROW_W'(p_q);
				end else begin
					col_q <= ncol;
				end
			end
			if (cmd.adv) begin
				rowb_q <= rowb_q + prod_q;
				col_q  <= rem_q;
			end
			if (cmd.init) begin
				phase_q  <= PH_LEN0;
				held_q   <= '0;
				runlen_q <= '0;
				runcol_q <= BLACK;
				col_q    <= '0;
				rowb_q   <= '0;
				pl_q     <= area_q;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= in_data;
		if (cmd.parse) begin
			len_q  <= run_len;
			fcol_q <= run_col;
		end
		if (cmd.clip) begin
			len_q   <= clen;
			clip_q  <= over;
			ffull_q <= (len_q >= pl_q);
			off_q   <= rowb_q + ROW_W'(col_q);
		end
		if (cmd.place) begin
			rem_q <= '0;
			if (is_short) begin
				head_q <= len_q[WIDTH_W-1:0];
				quot_q <= '0;
			end else begin
				head_q <= room;
				quot_q <= DIV_W'(len_q - PL_W'(room));
			end
		end
		if (cmd.div_step) begin
			quot_q <= q_nx;
			rem_q  <= r_nx;
		end
		if (cmd.mul) prod_q <= prod_w[ROW_W-1:0];
		if (cmd.emit) begin
			out_data.start_offset <= off_q;
			out_data.head_len     <= head_q;
			out_data.full_rows    <= quot_q[FULL_W-1:0];
			out_data.tail_len     <= rem_q[TAIL_W-1:0];
			out_data.fill_color   <= fcol_q;
			out_data.clipped      <= clip_q;
			out_data.frame_full   <= ffull_q;
		end
	end

	assign out_valid = out_valid_q;

	property p_clip_fills;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit && clip_q |-> ffull_q;
	endproperty
	a_clip_fills: assert property (p_clip_fills) else $error("clipped run left pixels");

	property p_head_nonzero;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> head_q != '0;
	endproperty
	a_head_nonzero: assert property (p_head_nonzero) else $error("empty head on fill");

	property p_tail_in_row;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> rem_q < w_q;
	endproperty
	a_tail_in_row: assert property (p_tail_in_row) else $error("tail beyond row width");

	property p_pl_only_reload;
		@(posedge clk) disable iff (!arst_n)
		pl_q > $past(pl_q) |-> $past(cmd.init);
	endproperty
	a_pl_only_reload: assert property (p_pl_only_reload) else $error("pixels left grew");

endmodule

/* sv/rle_frame_span_decoder_unit.sv */
// Run-length frame span decoder: top level.
// Input channel: in_valid / in_stall with an in_item_t (end-of-frame flag and
// one compressed byte). Output channel: out_valid / out_stall with one fill
// command (offset, head, full rows, tail, colour, clipped, frame full).
// Config channel: cfg_valid / cfg_ready, cfg_index selects width, height,
// pitch, varint mode, binary mode; written only while the block is idle.
// One item is in work at a time. A byte that finishes no run stalls the input
// while it is parsed. A run that ends on its starting row passes parse, clip,
// place and emit before out_valid rises; one that wraps rows also runs the
// divider at 4 quotient bits a cycle, then the pitch multiply and cursor add.
// End of frame adds an init state to reload the pixel count. A width, height
// or pitch write holds off input through the wait and init states while the
// frame area is recomputed. The output register frees the input side: a new
// item is taken while a fill waits, and the next fill waits for out_stall low.
// Reset: width, height, pitch 1, both modes 0, cursor at origin, colour black.
// Depends on rfsd_pkg, rfsd_ctrl, rfsd_dpath.
`timescale 1ns / 1ps

module rle_frame_span_decoder_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_PITCH  = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rfsd_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output rfsd_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rfsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfsd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rfsd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	rfsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.st        (st),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	rfsd_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_PITCH  (MAX_PITCH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* verif/rfsd_span_checker.sv */
// Run-length frame span decoder: fill-command checker.
// Watches the config, input and output channels, predicts each fill and compares
// it field by field. Depends on rfsd_pkg.
`timescale 1ns / 1ps

module rfsd_span_checker #(
	parameter int   MAX_WIDTH  = 1024,
	parameter int   MAX_HEIGHT = 1024,
	parameter int   MAX_PITCH  = 2048,
	parameter logic OP_EOF     = 1'b1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  rfsd_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  rfsd_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rfsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfsd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending,
	output int                              fills_seen
);
	import rfsd_pkg::*;

	localparam int unsigned ROW_MASK = (1 << ROW_W) - 1;

	typedef enum logic [1:0] {
		TOK_LEN_LO,
		TOK_LEN_HI,
		TOK_COL_LO,
		TOK_COL_HI
	} tok_phase_t;

	logic [WIDTH_W-1:0]  geo_width;
	logic [HEIGHT_W-1:0] geo_height;
	logic [PITCH_W-1:0]  geo_pitch;
	logic                varint_on;
	logic                binary_on;

	tok_phase_t          tok_phase;
	logic [7:0]          tok_byte;
	logic [15:0]         run_len;
	logic [COLOR_W-1:0]  run_colour;
	int unsigned         cur_col;
	int unsigned         row_base;
	int unsigned         px_left;

	out_item_t           fill_q[$];

	function automatic int unsigned eff_width();
		int unsigned w;
		w = 32'(geo_width);
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = 32'(geo_height);
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	function automatic int unsigned eff_pitch();
		int unsigned p;
		p = 32'(geo_pitch);
		if (p > MAX_PITCH) p = MAX_PITCH;
		if (p < eff_width()) p = eff_width();
		return p;
	endfunction

	task automatic new_frame();
		tok_phase  = TOK_LEN_LO;
		tok_byte   = '0;
		run_len    = '0;
		run_colour = BLACK;
		cur_col    = 0;
		row_base   = 0;
		px_left    = eff_width() * eff_height();
	endtask

	task automatic place_fill(input int unsigned len, input logic [COLOR_W-1:0] colour);
		int unsigned w, p, room, rest, head, full, tail;
		out_item_t f;
		w = eff_width();
		p = eff_pitch();
		if (len == 0 || px_left == 0) return;
		f = '0;
		f.clipped = len > px_left;
		if (f.clipped) len = px_left;
		px_left -= len;
		if (cur_col >= w) cur_col = 0;
		room = w - cur_col;
		f.start_offset = ROW_W'(row_base + cur_col);
		full = 0;
		tail = 0;
		if (len <= room) begin
			head = len;
			cur_col += len;
			if (cur_col >= w) begin
				cur_col = 0;
				row_base = (row_base + p) & ROW_MASK;
			end
		end else begin
			rest = len - room;
			head = room;
			full = rest / w;
			tail = rest % w;
			row_base = (row_base + p * (full + 1)) & ROW_MASK;
			cur_col = tail;
		end
		f.head_len   = WIDTH_W'(head);
		f.full_rows  = FULL_W'(full);
		f.tail_len   = TAIL_W'(tail);
		f.fill_color = colour;
		f.frame_full = px_left == 0;
		fill_q.push_back(f);
	endtask

	task automatic length_done(input logic [15:0] len);
		run_len = len;
		if (!binary_on) begin
			tok_phase = TOK_COL_LO;
			return;
		end
		tok_phase = TOK_LEN_LO;
		place_fill(32'(run_len), run_colour);
		run_colour = ~run_colour;
	endtask

	task automatic take_item(input in_item_t it);
		if (it.opcode == OP_EOF) begin
			if (px_left != 0) place_fill(px_left, BLACK);
			new_frame();
			return;
		end
		if (px_left == 0) return;
		case (tok_phase)
			TOK_LEN_LO: begin
				if (varint_on && (it.byte_value & VARINT_CONT) == '0) begin
					length_done({8'h00, it.byte_value});
				end else begin
					tok_byte  = varint_on ? (it.byte_value & VARINT_MASK) : it.byte_value;
					tok_phase = TOK_LEN_HI;
				end
			end
			TOK_LEN_HI: begin
				if (varint_on) length_done({tok_byte, it.byte_value});
				else length_done({it.byte_value, tok_byte});
			end
			TOK_COL_LO: begin
				tok_byte  = it.byte_value;
				tok_phase = TOK_COL_HI;
			end
			default: begin
				run_colour = {it.byte_value, tok_byte};
				tok_phase  = TOK_LEN_LO;
				place_fill(32'(run_len), run_colour);
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_FRAME_WIDTH: begin
				geo_width = val[WIDTH_W-1:0];
				new_frame();
			end
			REG_FRAME_HEIGHT: begin
				geo_height = val[HEIGHT_W-1:0];
				new_frame();
			end
			REG_LINE_PITCH: begin
				geo_pitch = val[PITCH_W-1:0];
				new_frame();
			end
			REG_VARINT_MODE: varint_on = val[0];
			REG_BINARY_MODE: binary_on = val[0];
			default: ;
		endcase
	endtask

	task automatic report(input string what, input out_item_t want, input out_item_t got);
		if (errors < 10) begin
			$display("%0t fill mismatch (%s)", $time, what);
			$display("  exp off=%0d head=%0d rows=%0d tail=%0d col=%h clip=%b full=%b",
				want.start_offset, want.head_len, want.full_rows, want.tail_len,
				want.fill_color, want.clipped, want.frame_full);
			$display("  got off=%0d head=%0d rows=%0d tail=%0d col=%h clip=%b full=%b",
				got.start_offset, got.head_len, got.full_rows, got.tail_len,
				got.fill_color, got.clipped, got.frame_full);
		end
		errors++;
	endtask

	task automatic check_fill(input out_item_t got);
		out_item_t want;
		string diff;
		fills_seen++;
		if (fill_q.size() == 0) begin
			report("no fill expected", '0, got);
			return;
		end
		want = fill_q.pop_front();
		diff = "";
		if (got.start_offset !== want.start_offset) diff = {diff, " start_offset"};
		if (got.head_len !== want.head_len) diff = {diff, " head_len"};
		if (got.full_rows !== want.full_rows) diff = {diff, " full_rows"};
		if (got.tail_len !== want.tail_len) diff = {diff, " tail_len"};
		if (got.fill_color !== want.fill_color) diff = {diff, " fill_color"};
		if (got.clipped !== want.clipped) diff = {diff, " clipped"};
		if (got.frame_full !== want.frame_full) diff = {diff, " frame_full"};
		if (diff != "") report(diff, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_width  = 1;
			geo_height = 1;
			geo_pitch  = 1;
			varint_on  = 1'b0;
			binary_on  = 1'b0;
			new_frame();
			fill_q.delete();
			errors     = 0;
			fills_seen = 0;
		end else begin
			if (out_valid && !out_stall) check_fill(out_data);
			if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) take_item(in_data);
		end
		pending = fill_q.size();
	end

endmodule

/* verif/tb_rle_frame_span_decoder_unit.sv */
// Testbench top for the run-length frame span decoder.
// Drives directed and random compressed frames under several geometries and
// modes; rfsd_span_checker predicts and compares. Depends on rfsd_pkg.
`timescale 1ns / 1ps

module tb_rle_frame_span_decoder_unit;
	import rfsd_pkg::*;

	localparam logic OP_BYTE        = 1'b0;
	localparam logic OP_EOF         = 1'b1;
	localparam int   N_PHASES       = 12;
	localparam int   ITEMS_PER_PHASE = 155;
	localparam int   SETTLE         = 20;
	localparam int   CYCLE_LIMIT    = 500000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches, pending, fills_seen;
	int items_sent, reg_writes, cycle_count;
	int burst_left, gap_max, stall_level, stall_left;
	bit stall_now;
	bit cur_varint, cur_binary;
	logic [WIDTH_W-1:0]  geo_w;
	logic [HEIGHT_W-1:0] geo_h;
	int unsigned area;

	rle_frame_span_decoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rfsd_span_checker #(.OP_EOF(OP_EOF)) i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (mismatches),
		.pending    (pending),
		.fills_seen (fills_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
		end else begin
			stall_now = stall_level != 0 && $urandom_range(0, 3) < stall_level;
			out_stall <= stall_now;
			stall_left = stall_now ? $urandom_range(0, 4 * stall_level - 1) : $urandom_range(0, 9);
		end
	end

	task automatic send_item(input logic op, input logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gap_max != 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		in_data  = '{opcode: op, byte_value: b};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain_fills();
		in_valid   = 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		reg_writes++;
		case (idx)
			REG_FRAME_WIDTH:  geo_w = val[WIDTH_W-1:0];
			REG_FRAME_HEIGHT: geo_h = val[HEIGHT_W-1:0];
			REG_VARINT_MODE:  cur_varint = val[0];
			REG_BINARY_MODE:  cur_binary = val[0];
			default: ;
		endcase
		area = (geo_w == 0 ? 1 : geo_w > 1024 ? 1024 : 32'(geo_w)) *
			(geo_h == 0 ? 1 : geo_h > 1024 ? 1024 : 32'(geo_h));
	endtask

	function automatic int unsigned pick_len();
		int unsigned cap, hi, r;
		cap = cur_varint ? 32767 : 65535;
		hi = area / 5;
		if (hi < 2) hi = 2;
		if (hi > cap) hi = cap;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return cap;
		if (r == 2) return $urandom_range(0, cap);
		return $urandom_range(1, hi);
	endfunction

	task automatic send_run(input int unsigned len);
		logic [15:0] l, c;
		l = 16'(len);
		c = ($urandom_range(0, 7) == 0) ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
		if (cur_varint) begin
			if (l < 128 && $urandom_range(0, 7) != 0) begin
				send_item(OP_BYTE, l[7:0]);
			end else begin
				send_item(OP_BYTE, VARINT_CONT | {1'b0, l[14:8]});
				send_item(OP_BYTE, l[7:0]);
			end
		end else begin
			send_item(OP_BYTE, l[7:0]);
			send_item(OP_BYTE, l[15:8]);
		end
		if (!cur_binary) begin
			send_item(OP_BYTE, c[7:0]);
			send_item(OP_BYTE, c[15:8]);
		end
	endtask

	task automatic setup_phase(input int ph);
		logic [CFG_DATA_W-1:0] w, h, p;
		bit wr_geo, wr_pitch, wr_var, wr_bin, v, b;
		wr_geo   = 1;
		wr_pitch = 1;
		wr_var   = 1;
		wr_bin   = 1;
		case (ph)
			0: begin w = 0; h = 0; p = 0; v = 1; b = 1; end
			1: begin w = '1; h = '1; p = '1; v = 0; b = 0; end
			2: begin w = 1024; h = 1; p = 1024; v = 1; b = 0; end
			3: begin w = 1; h = 1024; p = 2048; v = 0; b = 1; end
			4: begin w = 9; h = 7; p = 3; v = 1; b = 1; end
			default: begin
				w = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 4095)) :
					CFG_DATA_W'($urandom_range(1, 40));
				h = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 4095)) :
					CFG_DATA_W'($urandom_range(1, 24));
				p = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 4095)) :
					CFG_DATA_W'(32'(w[WIDTH_W-1:0]) + $urandom_range(0, 40));
				wr_geo   = $urandom_range(0, 1) == 1;
				wr_pitch = wr_geo || $urandom_range(0, 3) == 0;
				wr_var   = $urandom_range(0, 1) == 1;
				wr_bin   = $urandom_range(0, 1) == 1;
				v = $urandom_range(0, 1) == 1;
				b = $urandom_range(0, 1) == 1;
			end
		endcase
		if (wr_geo) write_reg(REG_FRAME_WIDTH, w);
		if (wr_geo) write_reg(REG_FRAME_HEIGHT, h);
		if (wr_pitch) write_reg(REG_LINE_PITCH, p);
		// upper data bits are don't-care for the mode flags
		if (wr_var) write_reg(REG_VARINT_MODE, {11'($urandom), v});
		if (wr_bin) write_reg(REG_BINARY_MODE, {11'($urandom), b});
		if (ph == 5) write_reg('1, '1);
	endtask

	initial begin : stimulus
		int ph, quota_end, r;
		bit paused;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		items_sent  = 0;
		reg_writes  = 0;
		burst_left  = 0;
		gap_max     = 0;
		stall_level = 0;
		stall_left  = 0;
		cur_varint  = 0;
		cur_binary  = 0;
		geo_w       = 1;
		geo_h       = 1;
		area        = 1;
		paused      = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset geometry: single pixel, u16 lengths, explicit 16-bit colour
		send_item(OP_BYTE, 8'h01);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hAA);
		send_item(OP_BYTE, 8'h55);
		drain_fills();

		// 4x4 window, pitch 6, varint lengths, implicit colour
		write_reg(REG_FRAME_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 4);
		write_reg(REG_LINE_PITCH, 6);
		write_reg(REG_VARINT_MODE, 1);
		write_reg(REG_BINARY_MODE, 1);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h03);
		send_item(OP_BYTE, 8'h80);
		send_item(OP_BYTE, 8'h05);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h42);
		send_item(OP_EOF, 8'hFF);
		send_item(OP_BYTE, 8'h85);
		send_item(OP_EOF, 8'h00);
		drain_fills();

		// same window, u16 lengths with explicit colour
		write_reg(REG_VARINT_MODE, 0);
		write_reg(REG_BINARY_MODE, 0);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h12);
		send_item(OP_BYTE, 8'h34);
		send_item(OP_BYTE, 8'h02);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h34);
		send_item(OP_BYTE, 8'h12);
		send_item(OP_EOF, 8'h5A);

		for (ph = 0; ph < N_PHASES; ph++) begin
			drain_fills();
			setup_phase(ph);
			case (ph % 3)
				0: begin gap_max = 0; stall_level = 0; end
				1: begin gap_max = 3; stall_level = 1; end
				default: begin gap_max = 8; stall_level = 2; end
			endcase
			quota_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < quota_end) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					send_item(OP_EOF, 8'($urandom_range(0, 255)));
				end else if (r < 14) begin
					send_item(OP_BYTE, 8'($urandom_range(0, 255)));
				end else if (r < 18) begin
					send_item(OP_BYTE, 8'($urandom_range(0, 255)));
					send_item(OP_EOF, 8'($urandom_range(0, 255)));
				end else begin
					send_run(pick_len());
				end
				if (!paused && ph == 4 && items_sent > quota_end - ITEMS_PER_PHASE / 2) begin
					drain_fills();
					paused = 1;
				end
			end
			// leave a token half read across the next register writes
			if ($urandom_range(0, 1)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		end
		stall_level = 0;
		drain_fills();

		$display("covered %0d items under %0d register writes, %0d geometry/mode settings",
			items_sent, reg_writes, N_PHASES + 3);
		$display("fills compared: %0d, mismatching: %0d", fills_seen, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/rfsd_pkg.sv
sv/rfsd_ctrl.sv
sv/rfsd_dpath.sv
sv/rle_frame_span_decoder_unit.sv
verif/rfsd_span_checker.sv
verif/tb_rle_frame_span_decoder_unit.sv
